// ----- hdl/tlts_pkg.sv -----
package tlts_pkg;

  localparam int TASK_ID_W = 6;
  localparam int PRIO_W    = 8;
  // Number of task ids that the id field can name
  localparam int ID_SPACE  = 1 << TASK_ID_W;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [TASK_ID_W-1:0] task_id;
    logic [PRIO_W-1:0]    task_priority;
    logic                 target_list;
  } req_t;

  typedef struct packed {
    logic                 run_valid;
    logic [TASK_ID_W-1:0] run_task;
    logic                 active_index;
    logic                 add_rejected;
  } rsp_t;

endpackage

// ----- hdl/tlts_ram.sv -----
module tlts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/two_list_time_slice_scheduler_core.sv -----
// Between accept and rsp_valid a refused add passes S_DONE, a tick S_TICK and S_DONE,
// an accepted add S_ADD_A, S_ADD_B and S_DONE, a tick ending a slice S_TICK, S_UNL,
// S_LNK_A, S_LNK_B and S_DONE. req_ready returns at the edge that registers the result,
// so a new word waits; one write port per link table sets the unlink and relink steps.
// rst (synchronous) empties both lists, clears present bits, slice count and choice;
// the link and slice tables are not cleared and are read only for listed tasks.
module two_list_time_slice_scheduler_core #(
  parameter int MAX_TASKS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tlts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tlts_pkg::rsp_t rsp
);

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int LINK_W = $clog2(MAX_TASKS + 1);
  // Link value that marks the end of a list or no task
  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_TASKS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADD_A = 8'b0000_0010,
    S_ADD_B = 8'b0000_0100,
    S_TICK  = 8'b0000_1000,
    S_UNL   = 8'b0001_0000,
    S_LNK_A = 8'b0010_0000,
    S_LNK_B = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Scheduler state
  logic [LINK_W-1:0]             head0, head0_next;
  logic [LINK_W-1:0]             head1, head1_next;
  logic [LINK_W-1:0]             cur, cur_next;
  logic [tlts_pkg::PRIO_W-1:0]   cnt, cnt_next;
  logic                          act, act_next;
  logic [tlts_pkg::ID_SPACE-1:0] present, present_next;

  // Word under work
  logic [IDX_W-1:0]              job, job_next;
  logic [tlts_pkg::PRIO_W-1:0]   prio, prio_next;
  logic                          tl, tl_next;
  logic                          rej, rej_next;

  // Table ports
  logic                          len_we;
  logic [IDX_W-1:0]              len_waddr;
  logic [tlts_pkg::PRIO_W-1:0]   len_wdata, len_q;
  logic                          nxt_we;
  logic [IDX_W-1:0]              nxt_waddr;
  logic [LINK_W-1:0]             nxt_wdata, nx_q;
  logic                          prv_we;
  logic [IDX_W-1:0]              prv_waddr;
  logic [LINK_W-1:0]             prv_wdata, pv_q;

  logic [31:0]                   req_id32;
  logic                          req_id_ok;
  logic [LINK_W-1:0]             job_link;
  logic [IDX_W-1:0]              cur_idx;
  logic [31:0]                   cur32;
  logic [tlts_pkg::PRIO_W-1:0]   cnt_inc;
  logic [LINK_W-1:0]             tgt_head;
  logic [LINK_W-1:0]             oth_head;
  logic                          do_choose;
  logic [LINK_W-1:0]             act_head;
  logic [LINK_W-1:0]             new_head;
  logic                          rsp_load;
  tlts_pkg::rsp_t                rsp_next;

  assign req_id32  = 32'(req.task_id);
  assign req_id_ok = req_id32 < 32'(MAX_TASKS);
  assign job_link  = LINK_W'(job);
  assign cur_idx   = cur[IDX_W-1:0];
  assign cur32     = 32'(cur);
  assign cnt_inc   = cnt + 1'b1;
  // Head of the list an add joins, and head of the list that is not active
  assign tgt_head  = tl ? head1 : head0;
  assign oth_head  = act ? head0 : head1;

  assign req_ready = (state == S_IDLE);

  // Slice length, next link and previous link tables; all reads follow the
  // running task so the data is ready in the cycle after accept.
  tlts_ram #(.DEPTH(MAX_TASKS), .WIDTH(tlts_pkg::PRIO_W)) u_len (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (cur_idx),
    .rdata (len_q)
  );

  tlts_ram #(.DEPTH(MAX_TASKS), .WIDTH(LINK_W)) u_next (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (cur_idx),
    .rdata (nx_q)
  );

  tlts_ram #(.DEPTH(MAX_TASKS), .WIDTH(LINK_W)) u_prev (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (cur_idx),
    .rdata (pv_q)
  );

  always_comb begin
    state_next   = state;
    head0_next   = head0;
    head1_next   = head1;
    cur_next     = cur;
    cnt_next     = cnt;
    act_next     = act;
    present_next = present;
    job_next     = job;
    prio_next    = prio;
    tl_next      = tl;
    rej_next     = rej;
    len_we       = 1'b0;
    len_waddr    = job;
    len_wdata    = prio;
    nxt_we       = 1'b0;
    nxt_waddr    = job;
    nxt_wdata    = NIL;
    prv_we       = 1'b0;
    prv_waddr    = job;
    prv_wdata    = NIL;
    do_choose    = 1'b0;
    act_head     = NIL;
    new_head     = NIL;

    unique case (state)
      S_IDLE: begin
        // Latch the word; an add is checked and marked present right away
        if (req_valid) begin
          job_next  = req_id32[IDX_W-1:0];
          prio_next = req.task_priority;
          tl_next   = req.target_list;
          rej_next  = 1'b0;
          if (req.opcode == tlts_pkg::OP_ADD) begin
            if (!req_id_ok || present[req.task_id]) begin
              rej_next   = 1'b1;
              state_next = S_DONE;
            end else begin
              present_next[req.task_id] = 1'b1;
              state_next = S_ADD_A;
            end
          end else begin
            state_next = S_TICK;
          end
        end
      end
      S_ADD_A: begin
        // Write the new task's slice and its links in front of the old head
        len_we     = 1'b1;
        nxt_we     = 1'b1;
        nxt_wdata  = tgt_head;
        prv_we     = 1'b1;
        state_next = S_ADD_B;
      end
      S_ADD_B: begin
        // Point the old head back at the new task, then move the head
        if (tgt_head < NIL) begin
          prv_we    = 1'b1;
          prv_waddr = tgt_head[IDX_W-1:0];
          prv_wdata = job_link;
        end
        if (tl) begin
          head1_next = job_link;
        end else begin
          head0_next = job_link;
        end
        state_next = S_DONE;
      end
      S_TICK: begin
        if (!(cur < NIL)) begin
          cnt_next   = '0;
          do_choose  = 1'b1;
          state_next = S_DONE;
        end else if (len_q == cnt_inc) begin
          cnt_next   = '0;
          state_next = S_UNL;
        end else begin
          cnt_next   = cnt_inc;
          state_next = S_DONE;
        end
      end
      S_UNL: begin
        // Unlink the running task: bridge its neighbors or advance a head
        if (pv_q < NIL) begin
          nxt_we    = 1'b1;
          nxt_waddr = pv_q[IDX_W-1:0];
          nxt_wdata = nx_q;
        end else if (head0 == cur) begin
          head0_next = nx_q;
        end else if (head1 == cur) begin
          head1_next = nx_q;
        end
        if (nx_q < NIL) begin
          prv_we    = 1'b1;
          prv_waddr = nx_q[IDX_W-1:0];
          prv_wdata = pv_q;
        end
        state_next = S_LNK_A;
      end
      S_LNK_A: begin
        // Relink it in front of the other list's head
        nxt_we     = 1'b1;
        nxt_waddr  = cur_idx;
        nxt_wdata  = oth_head;
        prv_we     = 1'b1;
        prv_waddr  = cur_idx;
        state_next = S_LNK_B;
      end
      S_LNK_B: begin
        if (oth_head < NIL) begin
          prv_we    = 1'b1;
          prv_waddr = oth_head[IDX_W-1:0];
          prv_wdata = cur;
        end
        if (act) begin
          head0_next = cur;
        end else begin
          head1_next = cur;
        end
        do_choose  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Hold until the result register is free
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Pick the head of the active list, swap lists if the active one is empty
    if (do_choose) begin
      act_head = act ? head1_next : head0_next;
      if (!(act_head < NIL)) begin
        act_next = ~act;
      end
      new_head = act_next ? head1_next : head0_next;
      cur_next = (new_head < NIL) ? new_head : NIL;
    end
  end

  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    rsp_next.run_valid    = (cur < NIL);
    rsp_next.run_task     = (cur < NIL) ? cur32[tlts_pkg::TASK_ID_W-1:0] : '0;
    rsp_next.active_index = act;
    rsp_next.add_rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head0     <= NIL;
      head1     <= NIL;
      cur       <= NIL;
      cnt       <= '0;
      act       <= 1'b0;
      present   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      head0   <= head0_next;
      head1   <= head1_next;
      cur     <= cur_next;
      cnt     <= cnt_next;
      act     <= act_next;
      present <= present_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job  <= job_next;
    prio <= prio_next;
    tl   <= tl_next;
    rej  <= rej_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // With no task running the slice count sits at zero
  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !(cur < NIL)) |-> (cnt == '0))
    else $error("slice count not cleared with no running task");

  // A running task is always a listed task
  a_cur_present: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && (cur < NIL)) |-> present[cur32[tlts_pkg::TASK_ID_W-1:0]])
    else $error("running task is not present");

  // A running task implies the active list is not empty
  a_active_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && (cur < NIL)) |-> ((act ? head1 : head0) < NIL))
    else $error("running task with an empty active list");
`endif

endmodule

// ----- verif/tb_two_list_time_slice_scheduler_core.sv -----
`timescale 1ns / 100ps

module tb_two_list_time_slice_scheduler_core;

  localparam int N_TASKS = tlts_pkg::ID_SPACE;
  localparam logic [6:0] NO_TASK = 7'(N_TASKS);

  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;
  localparam logic ADD_TAKEN = 1'b0;
  localparam logic ADD_REFUSED = 1'b1;

  localparam int RAND_ITEMS = 484;
  localparam int FILL_ITEMS = 200;     // add-heavy opening of the random part
  localparam int QUIET_TAIL = 100;     // last words run with no idling
  localparam int PRESSURE_AT = 100;    // falls in a stretch without sender gaps
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  tlts_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  tlts_pkg::rsp_t rsp;

  always #1 clk = ~clk;

  two_list_time_slice_scheduler_core #(
    .MAX_TASKS(N_TASKS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // ---------------------------------------------------------------------------
  // Scheduler mirror: two doubly linked run lists, slice counter, active list.
  // Link and slice tables are only read for tasks that are on a list.
  // ---------------------------------------------------------------------------
  logic [6:0] next_tab [N_TASKS];
  logic [6:0] prev_tab [N_TASKS];
  logic [tlts_pkg::PRIO_W-1:0] slice_len [N_TASKS];
  bit on_list [N_TASKS];
  logic [6:0] head_of [2] = '{NO_TASK, NO_TASK};
  logic [6:0] running = NO_TASK;
  logic [tlts_pkg::PRIO_W-1:0] slice_ticks = '0;
  logic act_list = LIST_A;

  tlts_pkg::rsp_t exp_q [$];
  int err_cnt = 0;
  int rsp_seen = 0;

  // Push a task onto the head of a list.
  function automatic void link_front(logic which, logic [6:0] t);
    logic [6:0] old;
    old = head_of[which];
    next_tab[t] = old;
    prev_tab[t] = NO_TASK;
    if (old != NO_TASK) prev_tab[old] = t;
    head_of[which] = t;
  endfunction

  // Swap lists if the active one ran dry, then run its head (or go idle).
  function automatic void pick_head();
    if (head_of[act_list] == NO_TASK) act_list = ~act_list;
    running = head_of[act_list];
  endfunction

  // Apply one word to the mirror and return the scheduling decision it reports.
  function automatic tlts_pkg::rsp_t sched_decide(tlts_pkg::req_t w);
    logic [6:0] t;
    logic [6:0] nx;
    logic [6:0] pv;
    tlts_pkg::rsp_t r;
    r = '0;
    r.add_rejected = ADD_TAKEN;
    if (w.opcode == tlts_pkg::OP_ADD) begin
      t = {1'b0, w.task_id};
      if (t >= NO_TASK || on_list[t]) begin
        r.add_rejected = ADD_REFUSED;
      end else begin
        on_list[t] = 1'b1;
        slice_len[t] = w.task_priority;
        link_front(w.target_list, t);
      end
    end else begin
      // 8-bit count: a slice length of zero wraps to 256 ticks
      slice_ticks = slice_ticks + 1'b1;
      if (running == NO_TASK) begin
        slice_ticks = '0;
        pick_head();
      end else if (slice_len[running] == slice_ticks) begin
        t = running;
        slice_ticks = '0;
        nx = next_tab[t];
        pv = prev_tab[t];
        if (pv != NO_TASK) next_tab[pv] = nx;
        else if (head_of[0] == t) head_of[0] = nx;
        else if (head_of[1] == t) head_of[1] = nx;
        if (nx != NO_TASK) prev_tab[nx] = pv;
        link_front(~act_list, t);
        pick_head();
      end
    end
    r.run_valid = (running != NO_TASK);
    r.run_task = r.run_valid ? running[tlts_pkg::TASK_ID_W-1:0] : '0;
    r.active_index = act_list;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed words. Rows marked known carry a hand-written result; the rest
  // take the mirror's decision.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic known;
    tlts_pkg::rsp_t want;
    tlts_pkg::req_t w;
  } dir_row_t;

  localparam int DIR_ROWS = 16;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // idle tick out of reset: empty active list swaps to the other empty list
    '{1'b1, '{1'b0, 6'd0, LIST_B, ADD_TAKEN}, '{tlts_pkg::OP_TICK, 6'd63, 8'd255, LIST_B}},
    '{1'b1, '{1'b0, 6'd0, LIST_A, ADD_TAKEN}, '{tlts_pkg::OP_TICK, 6'd0, 8'd0, LIST_A}},
    // add never changes the choice; a second add of the same id is refused
    '{1'b1, '{1'b0, 6'd0, LIST_A, ADD_TAKEN}, '{tlts_pkg::OP_ADD, 6'd0, 8'd1, LIST_A}},
    '{1'b1, '{1'b0, 6'd0, LIST_A, ADD_REFUSED}, '{tlts_pkg::OP_ADD, 6'd0, 8'd7, LIST_B}},
    // zero-length slice: runs 256 ticks once it gets the processor
    '{1'b1, '{1'b0, 6'd0, LIST_A, ADD_TAKEN}, '{tlts_pkg::OP_ADD, 6'd42, 8'd0, LIST_B}},
    '{1'b0, '0, '{tlts_pkg::OP_TICK, 6'd21, 8'd170, LIST_B}},
    '{1'b0, '0, '{tlts_pkg::OP_TICK, 6'd0, 8'd0, LIST_A}},
    '{1'b0, '0, '{tlts_pkg::OP_ADD, 6'd21, 8'd2, LIST_A}},
    '{1'b0, '0, '{tlts_pkg::OP_TICK, 6'd42, 8'd85, LIST_A}},
    '{1'b0, '0, '{tlts_pkg::OP_ADD, 6'd63, 8'd255, LIST_A}},
    '{1'b0, '0, '{tlts_pkg::OP_ADD, 6'd63, 8'd1, LIST_B}},
    '{1'b0, '0, '{tlts_pkg::OP_ADD, 6'd5, 8'd3, LIST_B}},
    '{1'b0, '0, '{tlts_pkg::OP_TICK, 6'd0, 8'd0, LIST_A}},
    '{1'b0, '0, '{tlts_pkg::OP_TICK, 6'd63, 8'd255, LIST_B}},
    '{1'b0, '0, '{tlts_pkg::OP_TICK, 6'd0, 8'd0, LIST_A}},
    '{1'b0, '0, '{tlts_pkg::OP_TICK, 6'd0, 8'd0, LIST_A}}
  };

  // Mostly short slices so the run lists rotate many times; now and then an
  // extreme length, including the wrapping zero.
  function automatic tlts_pkg::req_t rand_word(bit fill);
    tlts_pkg::req_t w;
    int pick;
    w.opcode = ($urandom_range(0, 99) < (fill ? 35 : 12)) ? tlts_pkg::OP_ADD : tlts_pkg::OP_TICK;
    w.task_id = tlts_pkg::TASK_ID_W'($urandom_range(0, N_TASKS - 1));
    w.target_list = $urandom_range(0, 1) ? LIST_B : LIST_A;
    pick = $urandom_range(0, 99);
    if (pick < 88) w.task_priority = tlts_pkg::PRIO_W'($urandom_range(1, 4));
    else if (pick < 97) w.task_priority = tlts_pkg::PRIO_W'($urandom_range(5, 255));
    else w.task_priority = $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: hold valid and payload until the word is taken, then record the
  // expected decision.
  // ---------------------------------------------------------------------------
  logic idle_en = 1'b1;
  logic hold_req = 1'b0;

  task automatic send_word(tlts_pkg::req_t w, logic known, tlts_pkg::rsp_t typed_rsp);
    tlts_pkg::rsp_t decided;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!req_ready);
    decided = sched_decide(w);
    exp_q.push_back(known ? typed_rsp : decided);
  endtask

  initial begin : stim
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < DIR_ROWS; i++) send_word(DIR_TAB[i].w, DIR_TAB[i].known, DIR_TAB[i].want);
    for (i = 0; i < RAND_ITEMS; i++) begin
      // idle in stretches, none in every third block of 50 and none at the end
      idle_en <= (i < RAND_ITEMS - QUIET_TAIL) && ((i / 50) % 3 != 2);
      if (i == PRESSURE_AT) hold_req <= 1'b1;
      send_word(rand_word(i < FILL_ITEMS), 1'b0, '0);
    end
    req_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** two_list_time_slice_scheduler_core: PASSED **");
    end else begin
      $display("** two_list_time_slice_scheduler_core: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off so
  // the block keeps its result and backs up the request side.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      rsp_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each taken word with the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_err(string what, int got, int want);
    $display("ERROR t=%0t word %0d: %s got %0d expected %0d", $time, rsp_seen, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin : result_check
    tlts_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (exp_q.size() == 0) begin
        report_err("word with nothing pending, run_task", rsp.run_task, 0);
      end else begin
        want = exp_q.pop_front();
        if (rsp.run_valid !== want.run_valid)
          report_err("run_valid", rsp.run_valid, want.run_valid);
        if (rsp.run_task !== want.run_task)
          report_err("run_task", rsp.run_task, want.run_task);
        if (rsp.active_index !== want.active_index)
          report_err("active_index", rsp.active_index, want.active_index);
        if (rsp.add_rejected !== want.add_rejected)
          report_err("add_rejected", rsp.add_rejected, want.add_rejected);
      end
      rsp_seen++;
    end
  end

  // Drop the run if no word moves on either side for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** two_list_time_slice_scheduler_core: FAILED **");
      $finish;
    end
  end

endmodule
